### design/srvp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SRV rdata parser package
// Shared result type, status codes and sizes of the SRV rdata parser.
// ----------------------------------------------------------------------------
package srvp_pkg;

	localparam int unsigned HDR_BYTES   = 6;
	localparam int unsigned MIN_LEN     = 7;
	localparam logic [7:0]  PTR_MASK    = 8'hC0;
	localparam logic [7:0]  DOT_CHAR    = 8'h2E;
	localparam logic [15:0] SRV_TYPE_RST = 16'd33;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic {
		KIND_CHAR    = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TOO_SHORT = 3'd1,
		ST_POINTER   = 3'd2,
		ST_TRUNCATED = 3'd3,
		ST_NO_TERM   = 3'd4,
		ST_WRONG_TYPE = 3'd5
	} status_t;

	typedef struct packed {
		kind_t       result_kind;
		logic [7:0]  name_char;
		logic [15:0] priority_res;
		logic [15:0] weight;
		logic [15:0] port;
		logic [31:0] ttl_out;
		status_t     status;
		logic        last_of_run;
	} result_t;

	// Results of one input byte, in order; cnt says how many are valid.
	typedef struct packed {
		logic [1:0] cnt;
		result_t    res0;
		result_t    res1;
	} push_t;

endpackage : srvp_pkg
`default_nettype wire

### design/srvp_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SRV rdata parser datapath
// Per-record state and the combinational decode of one rdata byte into up to
// two results: a name character and, on the last byte, the verdict.
// ----------------------------------------------------------------------------
module srvp_parser
	import srvp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        srv_type_we,
	input  wire logic [15:0] srv_type_wdata,
	input  wire logic        step,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_rdata,
	input  wire logic [15:0] record_type,
	input  wire logic [31:0] ttl,
	output push_t            push
);

	logic [15:0] srv_type_q;
	logic [2:0]  byte_index_q;
	logic [47:0] header_shift_q;
	logic [5:0]  label_left_q;
	logic        after_first_q;
	logic        name_done_q;
	status_t     error_code_q;

	logic [2:0]  nxt_byte_index;
	logic [47:0] nxt_header;
	logic [5:0]  nxt_label_left;
	logic        nxt_after_first;
	logic        nxt_name_done;
	status_t     nxt_error;
	logic        type_ok;
	logic        emit_char;
	logic [7:0]  char_val;
	status_t     verdict_st;
	result_t     char_res;
	result_t     verdict_res;

	assign type_ok = (record_type == srv_type_q);

	always_comb begin
		nxt_byte_index  = byte_index_q;
		nxt_header      = header_shift_q;
		nxt_label_left  = label_left_q;
		nxt_after_first = after_first_q;
		nxt_name_done   = name_done_q;
		nxt_error       = error_code_q;
		emit_char       = 1'b0;
		char_val        = data_byte;

		if (byte_index_q < 3'(HDR_BYTES)) begin
			nxt_header = {header_shift_q[39:0], data_byte};
		end else if (!name_done_q && error_code_q == ST_OK) begin
			priority if (label_left_q != 6'd0) begin
				nxt_label_left = label_left_q - 6'd1;
				emit_char      = type_ok;
			end else if ((data_byte & PTR_MASK) != 8'd0) begin
				nxt_error = ST_POINTER;
			end else if (data_byte == 8'd0) begin
				nxt_name_done = 1'b1;
			end else begin
				nxt_label_left  = data_byte[5:0];
				emit_char       = after_first_q && type_ok;
				char_val        = DOT_CHAR;
				nxt_after_first = 1'b1;
			end
		end
		if (byte_index_q < 3'(MIN_LEN)) begin
			nxt_byte_index = byte_index_q + 3'd1;
		end
	end

	// Status is judged on the state as it stands after this byte.
	always_comb begin
		priority if (!type_ok) begin
			verdict_st = ST_WRONG_TYPE;
		end else if (nxt_byte_index < 3'(MIN_LEN)) begin
			verdict_st = ST_TOO_SHORT;
		end else if (nxt_error != ST_OK) begin
			verdict_st = nxt_error;
		end else if (nxt_label_left != 6'd0) begin
			verdict_st = ST_TRUNCATED;
		end else if (!nxt_name_done) begin
			verdict_st = ST_NO_TERM;
		end else begin
			verdict_st = ST_OK;
		end
	end

	always_comb begin
		char_res             = '0;
		char_res.result_kind = KIND_CHAR;
		char_res.name_char   = char_val;
		char_res.last_of_run = !end_of_rdata;

		verdict_res             = '0;
		verdict_res.result_kind = KIND_VERDICT;
		verdict_res.ttl_out     = ttl;
		verdict_res.status      = verdict_st;
		verdict_res.last_of_run = 1'b1;
		if (verdict_st == ST_OK) begin
			verdict_res.priority_res = nxt_header[47:32];
			verdict_res.weight       = nxt_header[31:16];
			verdict_res.port         = nxt_header[15:0];
		end

		push      = '0;
		push.res1 = verdict_res;
		if (!step) begin
			push.cnt  = 2'd0;
			push.res0 = char_res;
		end else if (emit_char) begin
			push.cnt  = end_of_rdata ? 2'd2 : 2'd1;
			push.res0 = char_res;
		end else begin
			push.cnt  = end_of_rdata ? 2'd1 : 2'd0;
			push.res0 = verdict_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srv_type_q     <= SRV_TYPE_RST;
			byte_index_q   <= '0;
			header_shift_q <= '0;
			label_left_q   <= '0;
			after_first_q  <= 1'b0;
			name_done_q    <= 1'b0;
			error_code_q   <= ST_OK;
		end else begin
			if (srv_type_we) begin
				srv_type_q <= srv_type_wdata;
			end
			if (step) begin
				if (end_of_rdata) begin
					byte_index_q   <= '0;
					header_shift_q <= '0;
					label_left_q   <= '0;
					after_first_q  <= 1'b0;
					name_done_q    <= 1'b0;
					error_code_q   <= ST_OK;
				end else begin
					byte_index_q   <= nxt_byte_index;
					header_shift_q <= nxt_header;
					label_left_q   <= nxt_label_left;
					after_first_q  <= nxt_after_first;
					name_done_q    <= nxt_name_done;
					error_code_q   <= nxt_error;
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_two_is_char_then_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt == 2'd2) |-> (push.res0.result_kind == KIND_CHAR
			&& push.res1.result_kind == KIND_VERDICT))
		else $error("two results must be a character followed by a verdict");
	a_last_clears_index: assert property (@(posedge clk) disable iff (!arst_n)
		(step && end_of_rdata) |=> (byte_index_q == 3'd0))
		else $error("record state not cleared after the last byte");
	a_index_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		byte_index_q <= 3'(MIN_LEN))
		else $error("byte index ran past its saturation value");
`endif

endmodule : srvp_parser
`default_nettype wire

### design/srvp_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SRV rdata parser result queue
// Small register queue that takes up to two results per cycle and hands
// out one per transfer on the result stream.
// ----------------------------------------------------------------------------
module srvp_out_fifo
	import srvp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  push_t     push,
	output logic      room,
	output logic      m_valid,
	input  wire logic m_ready,
	output result_t   m_res
);

	result_t                entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  wr_ptr_q;
	logic [FIFO_PTR_W-1:0]  rd_ptr_q;
	logic [FIFO_CNT_W-1:0]  count_q;
	logic                   pop;
	logic [FIFO_PTR_W-1:0]  wr_ptr_p1;

	assign m_valid   = (count_q != '0);
	assign pop       = m_valid && m_ready;
	assign m_res     = entry_q[rd_ptr_q];
	assign wr_ptr_p1 = wr_ptr_q + FIFO_PTR_W'(1);
	// Room for the worst case of two results from one byte. A transfer in the
	// same cycle frees one entry, which is enough only when a single entry is free.
	assign room = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2))
		|| (pop && count_q == FIFO_CNT_W'(FIFO_DEPTH - 1));

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			entry_q[wr_ptr_q] <= push.res0;
		end
		if (push.cnt == 2'd2) begin
			entry_q[wr_ptr_p1] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			count_q <= count_q + FIFO_CNT_W'(push.cnt) - FIFO_CNT_W'(pop);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("result queue overflow");
	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> room)
		else $error("results pushed without room");
	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0 && !pop) |=>
			(count_q == $past(count_q) + FIFO_CNT_W'($past(push.cnt))))
		else $error("queue count does not follow the pushes");
`endif

endmodule : srvp_out_fifo
`default_nettype wire

### design/srv_rdata_parser_core.sv
`default_nettype none
// An accepted byte is held in the input stage until its results enter the queue.
// Throughput: one byte per cycle while the result queue has room; a byte that
// causes a character and a verdict occupies the result stream for two transfers,
// absorbed by a four-entry queue.
// Reset: arst_n clears the record state, the queue and the input stage at once
// and sets srv_type to 33.
// ----------------------------------------------------------------------------
// SRV rdata parser core
// Streams SRV rdata bytes in and emits dotted name characters and verdicts.
// ----------------------------------------------------------------------------
module srv_rdata_parser_core
	import srvp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        srv_type_we,
	input  wire logic [15:0] srv_type_wdata,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // data_byte[7:0], ttl[39:8]
	input  wire logic        s_axis_tlast,
	input  wire logic [15:0] s_axis_tuser,  // record_type[15:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// name_char[7:0], priority_res[23:8], weight[39:24], port[55:40],
	// ttl_out[87:56], status[90:88], zero[95:91]
	output logic [95:0]      m_axis_tdata,
	output logic             m_axis_tlast,
	output logic             m_axis_tuser   // result_kind
);

	logic        valid_s1;
	logic [7:0]  data_byte_s1;
	logic        end_s1;
	logic [15:0] record_type_s1;
	logic [31:0] ttl_s1;
	logic        room;
	logic        advance;
	push_t       push;
	result_t     m_res;

	assign advance       = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_byte_s1   <= s_axis_tdata[7:0];
			ttl_s1         <= s_axis_tdata[39:8];
			end_s1         <= s_axis_tlast;
			record_type_s1 <= s_axis_tuser;
		end
	end

	srvp_parser u_parser (
		.clk            (clk),
		.arst_n         (arst_n),
		.srv_type_we    (srv_type_we),
		.srv_type_wdata (srv_type_wdata),
		.step           (advance),
		.data_byte      (data_byte_s1),
		.end_of_rdata   (end_s1),
		.record_type    (record_type_s1),
		.ttl            (ttl_s1),
		.push           (push)
	);

	srvp_out_fifo u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.room    (room),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_res   (m_res)
	);

	assign m_axis_tdata = {5'b0, m_res.status, m_res.ttl_out, m_res.port, m_res.weight,
		m_res.priority_res, m_res.name_char};
	assign m_axis_tlast = m_res.last_of_run;
	assign m_axis_tuser = m_res.result_kind;

`ifndef NO_ASSERTIONS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stalled with an empty input stage");
	a_hold_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !room) |=> (valid_s1 && $stable(data_byte_s1) && $stable(end_s1)))
		else $error("input stage lost a byte while the queue was full");
	a_push_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> advance)
		else $error("results produced without a byte advancing");
`endif

endmodule : srv_rdata_parser_core
`default_nettype wire
